// ===== rtl/ffrq_pkg.sv =====
// shared types and codes for the frame fenced release queue
package ffrq_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 32;
   localparam logic [3:0] FIF_RESET = 4'd2;

   localparam logic [1:0] OP_RETIRE  = 2'd0;
   localparam logic [1:0] OP_COLLECT = 2'd1;
   localparam logic [1:0] OP_QUERY   = 2'd2;

   localparam logic [2:0] RK_ACCEPTED = 3'd0;
   localparam logic [2:0] RK_FULL     = 3'd1;
   localparam logic [2:0] RK_NULL     = 3'd2;
   localparam logic [2:0] RK_RELEASE  = 3'd3;
   localparam logic [2:0] RK_DONE     = 3'd4;
   localparam logic [2:0] RK_QUERY    = 3'd5;

   typedef struct packed {
      logic        kind;
      logic [63:0] handle;
      logic [63:0] memory;
      logic [63:0] frame;
   } entry_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

// ===== rtl/ffrq_cell.sv =====
// one table slot: loads a new entry or takes its upper neighbor's entry
module ffrq_cell import ffrq_pkg::*; #(
   parameter int IDX_W = 5,
   parameter int CELL_INDEX = 0
) (
   input  logic             clock,
   input  cell_ctl_type     ctl,
   input  logic [IDX_W-1:0] load_idx,
   input  entry_type        load_data,
   input  entry_type        next_data,
   output entry_type        data
);

   entry_type data_ff;
   entry_type data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.load && (load_idx == IDX_W'(CELL_INDEX))) begin
         data_in = load_data;
      end else if (ctl.shift) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== rtl/frame_fenced_release_queue_unit.sv =====
// top level of the frame fenced release queue: control, age test and cell chain
//
// Usage: an item is taken on a rising edge with start high and busy low.
// Retire and query items are answered in the next cycle with a single result,
// and another retire or query may follow in the very next cycle.
// An end-of-frame item walks the table through the cell chain: each cycle the
// head cell's entry is tested and either sent out as a release result or
// written back behind the kept entries while the chain shifts down by one.
// The walk ends with the done result, and busy stays high while it runs.
// Results sit on the rsp_ ports for exactly one cycle marked by rsp_valid;
// the receiver cannot stall them.
// The frames_in_flight register is written through csr_valid/csr_data and
// csr_ready is always high; write it only while the block is idle.
// Reset (synchronous) clears the entry count, frame counter and control and
// sets frames_in_flight to 2; table contents are left as they are.
module frame_fenced_release_queue_unit import ffrq_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic        req_resource_kind,
   input  logic [63:0] req_object_handle,
   input  logic [63:0] req_memory_handle,
   input  logic [63:0] req_query_frame,
   output logic        rsp_valid,
   output logic [2:0]  rsp_result_kind,
   output logic        rsp_released_kind,
   output logic [63:0] rsp_released_handle,
   output logic [63:0] rsp_released_memory,
   output logic [63:0] rsp_current_frame,
   output logic        rsp_frame_finished,
   output logic        rsp_last_result,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_data
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   typedef enum logic {IDLE, COLLECT} state_type;

   state_type   state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] remain_ff, remain_in;
   logic [CNT_W-1:0] kept_ff, kept_in;
   logic [63:0] frame_ff, frame_in;
   logic [3:0]  fif_ff, fif_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_kind_ff, rsp_kind_in;
   logic        rsp_rkind_ff, rsp_rkind_in;
   logic [63:0] rsp_handle_ff, rsp_handle_in;
   logic [63:0] rsp_memory_ff, rsp_memory_in;
   logic [63:0] rsp_frame_ff, rsp_frame_in;
   logic        rsp_fin_ff, rsp_fin_in;
   logic        rsp_last_ff, rsp_last_in;

   entry_type    cell_data [TABLE_DEPTH];
   entry_type    load_data;
   cell_ctl_type ctl;
   logic [IDX_W-1:0] load_idx;
   logic [CNT_W-1:0] tail_pos;

   logic [63:0] head_age, query_age;
   logic        head_old, query_old, accept;

   assign accept    = start && (state_ff == IDLE);
   assign head_age  = frame_ff - cell_data[0].frame;
   assign head_old  = head_age > {60'd0, fif_ff};
   assign query_age = frame_ff - req_query_frame;
   assign query_old = query_age > {60'd0, fif_ff};
   // kept entries go right behind the ones still waiting to be tested
   assign tail_pos  = remain_ff + kept_ff - CNT_W'(1);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      remain_in     = remain_ff;
      kept_in       = kept_ff;
      frame_in      = frame_ff;
      fif_in        = fif_ff;
      rsp_valid_in  = 1'b0;
      rsp_kind_in   = RK_ACCEPTED;
      rsp_rkind_in  = 1'b0;
      rsp_handle_in = 64'd0;
      rsp_memory_in = 64'd0;
      rsp_frame_in  = frame_ff;
      rsp_fin_in    = 1'b0;
      rsp_last_in   = 1'b1;
      ctl           = '{shift: 1'b0, load: 1'b0};
      load_idx      = count_ff[IDX_W-1:0];
      load_data.kind   = req_resource_kind;
      load_data.handle = req_object_handle;
      load_data.memory = req_memory_handle;
      load_data.frame  = frame_ff;

      if (csr_valid) begin
         fif_in = csr_data;
      end

      case (state_ff)
         IDLE: begin
            if (accept) begin
               case (req_operation)
                  OP_RETIRE: begin
                     rsp_valid_in = 1'b1;
                     if (req_object_handle == 64'd0) begin
                        rsp_kind_in = RK_NULL;
                     end else if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                        rsp_kind_in = RK_FULL;
                     end else begin
                        rsp_kind_in = RK_ACCEPTED;
                        ctl.load    = 1'b1;
                        count_in    = count_ff + CNT_W'(1);
                     end
                  end
                  OP_COLLECT: begin
                     state_in  = COLLECT;
                     remain_in = count_ff;
                     kept_in   = '0;
                  end
                  OP_QUERY: begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = RK_QUERY;
                     rsp_fin_in   = query_old;
                  end
                  default: begin
                  end
               endcase
            end
         end
         COLLECT: begin
            if (remain_ff != '0) begin
               ctl.shift = 1'b1;
               remain_in = remain_ff - CNT_W'(1);
               load_data = cell_data[0];
               load_idx  = tail_pos[IDX_W-1:0];
               if (head_old) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = RK_RELEASE;
                  rsp_rkind_in  = cell_data[0].kind;
                  rsp_handle_in = cell_data[0].handle;
                  rsp_memory_in = cell_data[0].memory;
                  rsp_last_in   = 1'b0;
               end else begin
                  ctl.load = 1'b1;
                  kept_in  = kept_ff + CNT_W'(1);
               end
            end else begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = RK_DONE;
               count_in     = kept_ff;
               frame_in     = frame_ff + 64'd1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         kept_ff      <= '0;
         frame_ff     <= 64'd0;
         fif_ff       <= FIF_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         kept_ff      <= kept_in;
         frame_ff     <= frame_in;
         fif_ff       <= fif_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_kind_ff   <= rsp_kind_in;
      rsp_rkind_ff  <= rsp_rkind_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_memory_ff <= rsp_memory_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_fin_ff    <= rsp_fin_in;
      rsp_last_ff   <= rsp_last_in;
   end

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      entry_type next_data;
      if (i == TABLE_DEPTH - 1) begin : g_tail
         assign next_data = cell_data[i];
      end else begin : g_body
         assign next_data = cell_data[i+1];
      end
      ffrq_cell #(
         .IDX_W(IDX_W),
         .CELL_INDEX(i)
      ) u_cell (
         .clock(clock),
         .ctl(ctl),
         .load_idx(load_idx),
         .load_data(load_data),
         .next_data(next_data),
         .data(cell_data[i])
      );
   end

   assign busy                = (state_ff != IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = rsp_kind_ff;
   assign rsp_released_kind   = rsp_rkind_ff;
   assign rsp_released_handle = rsp_handle_ff;
   assign rsp_released_memory = rsp_memory_ff;
   assign rsp_current_frame   = rsp_frame_ff;
   assign rsp_frame_finished  = rsp_fin_ff;
   assign rsp_last_result     = rsp_last_ff;

endmodule
